// ----- rtl/ppu_pkg.sv -----
// ----------------------------------------------------------------------------
// ppu_pkg
// Shared types, register indexes and pixel mapping for the packed pixel
// unpacker.
// ----------------------------------------------------------------------------
package ppu_pkg;

  localparam int CoordWidth = 11;
  localparam int LevelWidth = 3;
  localparam int DimWidth   = 12;
  localparam int LanesMax   = 8;

  // register indexes on the configuration port
  localparam logic [2:0] REG_PIXEL_FORMAT     = 3'd0;
  localparam logic [2:0] REG_IMAGE_WIDTH      = 3'd1;
  localparam logic [2:0] REG_IMAGE_HEIGHT     = 3'd2;
  localparam logic [2:0] REG_MONO_SET_LEVEL   = 3'd3;
  localparam logic [2:0] REG_MONO_CLEAR_LEVEL = 3'd4;
  localparam logic [2:0] REG_COLOR_PALETTE    = 3'd5;

  // pixel format codes; the unused code decodes as mono
  localparam logic [1:0] FMT_MONO   = 2'd0;
  localparam logic [1:0] FMT_GRAY16 = 2'd1;
  localparam logic [1:0] FMT_COLOR6 = 2'd2;

  typedef struct packed {
    logic [1:0]            pixel_format;
    logic [DimWidth-1:0]   image_width;
    logic [DimWidth-1:0]   image_height;
    logic [LevelWidth-1:0] mono_set_level;
    logic [LevelWidth-1:0] mono_clear_level;
    logic [23:0]           color_palette;
  } ppu_cfg_t;

  // one decoded byte: start column, row, levels (pixel i at bits 3i+2..3i)
  // and the number of pixels to send
  typedef struct packed {
    logic [CoordWidth-1:0]            x;
    logic [CoordWidth-1:0]            y;
    logic [LanesMax*LevelWidth-1:0]   levels;
    logic [3:0]                       count;
  } ppu_job_t;

  function automatic logic [LevelWidth-1:0] ppu_map_nibble(
      input logic [1:0]  fmt,
      input logic [23:0] palette,
      input logic [3:0]  nib);
    logic [4:0] base;
    base = 5'({2'b00, nib[2:0]} * 5'd3);
    if (fmt == FMT_GRAY16) begin
      return nib[3:1];
    end
    return palette[base +: LevelWidth];
  endfunction

endpackage

// ----- rtl/ppu_decode.sv -----
// ----------------------------------------------------------------------------
// ppu_decode
// Byte column and row tracking; turns one accepted byte into a registered
// pixel job.
// ----------------------------------------------------------------------------
module ppu_decode #(
  parameter int MAX_DIM = 2048
) (
  input  logic              clk,
  input  logic              rst,
  input  ppu_pkg::ppu_cfg_t cfg,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,
  input  logic              s_tuser,
  output logic              job_valid,
  input  logic              job_ready,
  output ppu_pkg::ppu_job_t job
);
  import ppu_pkg::*;

  logic [CoordWidth-1:0] byte_column, byte_column_next;
  logic [DimWidth-1:0]   row_index, row_index_next;

  logic [DimWidth-1:0]   w, h, stride;
  logic                  mono;
  logic [CoordWidth-1:0] col0, col1, col_inc;
  logic [DimWidth-1:0]   row0, row1;
  logic                  stride_zero, past0, wrap, past1, wrap2, emit, accept;
  logic [DimWidth:0]     w_inc;
  logic [DimWidth-1:0]   x0;
  logic                  hi_ok, lo_ok;
  logic [LevelWidth-1:0] lvl_hi, lvl_lo;
  ppu_job_t              job_new;

  assign s_tready = !job_valid || job_ready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    // clamp dimensions
    w = ({1'b0, cfg.image_width} > (DimWidth+1)'(MAX_DIM)) ?
        DimWidth'(MAX_DIM) : cfg.image_width;
    h = ({1'b0, cfg.image_height} > (DimWidth+1)'(MAX_DIM)) ?
        DimWidth'(MAX_DIM) : cfg.image_height;
    mono   = !(cfg.pixel_format == FMT_GRAY16 || cfg.pixel_format == FMT_COLOR6);
    w_inc  = {1'b0, w} + 1'b1;
    stride = mono ? (w >> 3) : w_inc[DimWidth:1];

    col0 = s_tuser ? '0 : byte_column;
    row0 = s_tuser ? '0 : row_index;

    stride_zero = (stride == '0);
    past0       = (row0 >= h);
    wrap        = ({1'b0, col0} >= stride);
    col1        = wrap ? '0 : col0;
    row1        = wrap ? row0 + 1'b1 : row0;
    past1       = (row1 >= h);

    col_inc = col1 + 1'b1;
    wrap2   = ({1'b0, col_inc} >= stride);

    // 4bpp pixel positions and levels
    x0     = {col1, 1'b0};
    hi_ok  = (x0 < w);
    lo_ok  = ({1'b0, x0} + 1'b1) < {1'b0, w};
    lvl_hi = ppu_map_nibble(cfg.pixel_format, cfg.color_palette, s_tdata[7:4]);
    lvl_lo = ppu_map_nibble(cfg.pixel_format, cfg.color_palette, s_tdata[3:0]);

    job_new.y      = row1[CoordWidth-1:0];
    job_new.levels = '0;
    if (mono) begin
      job_new.x     = {col1[CoordWidth-4:0], 3'b000};
      job_new.count = 4'd8;
      for (int i = 0; i < LanesMax; i++) begin
        job_new.levels[i*LevelWidth +: LevelWidth] =
          s_tdata[7-i] ? cfg.mono_set_level : cfg.mono_clear_level;
      end
    end else if (hi_ok) begin
      job_new.x                   = x0[CoordWidth-1:0];
      job_new.levels[2:0]         = lvl_hi;
      job_new.levels[5:3]         = lvl_lo;
      job_new.count               = lo_ok ? 4'd2 : 4'd1;
    end else begin
      job_new.x                   = x0[CoordWidth-1:0] + 1'b1;
      job_new.levels[2:0]         = lvl_lo;
      job_new.count               = lo_ok ? 4'd1 : 4'd0;
    end

    emit = !stride_zero && !past0 && !past1 && (job_new.count != 4'd0);

    // counter update
    if (stride_zero || past0) begin
      byte_column_next = col0;
      row_index_next   = row0;
    end else if (past1) begin
      byte_column_next = col1;
      row_index_next   = row1;
    end else begin
      byte_column_next = wrap2 ? '0 : col_inc;
      row_index_next   = wrap2 ? row1 + 1'b1 : row1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_column <= '0;
      row_index   <= '0;
      job_valid   <= 1'b0;
    end else begin
      if (accept) begin
        byte_column <= byte_column_next;
        row_index   <= row_index_next;
      end
      job_valid <= (job_valid && !job_ready) || (accept && emit);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      job <= job_new;
    end
  end

endmodule

// ----- rtl/ppu_serial.sv -----
// ----------------------------------------------------------------------------
// ppu_serial
// Sends the pixels of one job, one per cycle while m_tready is high, from registered outputs.
// ----------------------------------------------------------------------------
module ppu_serial (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  output logic              job_ready,
  input  ppu_pkg::ppu_job_t job,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata,  // pixel_x[10:0], pixel_y[21:11], pixel_level[24:22]
  output logic              m_tlast   // last_of_byte
);
  import ppu_pkg::*;

  logic [CoordWidth-1:0]          cur_x;
  logic [CoordWidth-1:0]          cur_y;
  logic [LanesMax*LevelWidth-1:0] cur_levels;
  logic [3:0]                     remaining;

  assign m_tlast   = (remaining == 4'd1);
  assign job_ready = !m_tvalid || (m_tready && m_tlast);
  assign m_tdata   = {7'd0, cur_levels[LevelWidth-1:0], cur_y, cur_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (job_ready) begin
      m_tvalid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (job_ready) begin
      cur_x      <= job.x;
      cur_y      <= job.y;
      cur_levels <= job.levels;
      remaining  <= job.count;
    end else if (m_tready) begin
      // advance to the next pixel of this byte
      cur_x      <= cur_x + 1'b1;
      cur_levels <= cur_levels >> LevelWidth;
      remaining  <= remaining - 1'b1;
    end
  end

endmodule

// ----- rtl/packed_pixel_unpacker_core.sv -----
// ----------------------------------------------------------------------------
// packed_pixel_unpacker_core
// Unpacks a stream of packed 1bpp or 4bpp image bytes into one pixel
// request per pixel, with column, row and mapped level.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid / s_tready  data_byte in s_tdata, image_start in s_tuser
//  m_*       out        m_tvalid / m_tready  x, y, level in m_tdata, last_of_byte in m_tlast
//  cfg_*     in         cfg_we               register index and write data
//
//  A byte is registered as a job in the decode stage, then its pixels leave one
//  per cycle unless m_tready stalls: a mono byte sends 8 pixels, a 4bpp 1 or 2.
//  The output port rate of one pixel per cycle sets the sustained byte rate.
//  Bytes that emit nothing (past the last row, zero stride) are still accepted.
//  rst clears the counters and loads the register reset values.
//  A stalled m_tready holds the current pixel; one decoded byte waits in the
//  job register while the next byte request is held off.
//
module packed_pixel_unpacker_core #(
  parameter int MAX_DIM = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte[7:0]
  input  logic        s_tuser,   // image_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // pixel_x[10:0], pixel_y[21:11], pixel_level[24:22]
  output logic        m_tlast    // last_of_byte
);
  import ppu_pkg::*;

  ppu_cfg_t cfg;
  ppu_job_t job;
  logic     job_valid;
  logic     job_ready;

  // configuration registers; the user must write them only while the block is idle (not enforced here)
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_format     <= FMT_GRAY16;
      cfg.image_width      <= 12'd800;
      cfg.image_height     <= 12'd600;
      cfg.mono_set_level   <= 3'd0;
      cfg.mono_clear_level <= 3'd1;
      cfg.color_palette    <= 24'd2726216;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PIXEL_FORMAT:     cfg.pixel_format     <= cfg_data[1:0];
        REG_IMAGE_WIDTH:      cfg.image_width      <= cfg_data[11:0];
        REG_IMAGE_HEIGHT:     cfg.image_height     <= cfg_data[11:0];
        REG_MONO_SET_LEVEL:   cfg.mono_set_level   <= cfg_data[2:0];
        REG_MONO_CLEAR_LEVEL: cfg.mono_clear_level <= cfg_data[2:0];
        REG_COLOR_PALETTE:    cfg.color_palette    <= cfg_data;
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  // decode stage: counters and job formation
  ppu_decode #(
    .MAX_DIM (MAX_DIM)
  ) u_decode (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  // output stage: one pixel per cycle while m_tready is high
  ppu_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

`ifndef NO_ASSERTIONS
  // a waiting job is never lost or altered
  assert property (@(posedge clk) disable iff (rst)
    job_valid && !job_ready |=> job_valid && $stable(job))
    else $error("pending job changed while stalled");

  // pixels within one byte step the column by one
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=>
      m_tvalid && m_tdata[10:0] == $past(m_tdata[10:0]) + 11'd1)
    else $error("pixel column did not advance within a byte");

  // an idle output side always takes new input
  assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input held off while output idle");

  // the last pixel with no job waiting leaves the output empty
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast && !job_valid |=> !m_tvalid)
    else $error("output valid without a job");
`endif

endmodule
